// ===== rtl/core/rllf_pkg.sv =====
// Shared types, codes and constants of the running local linear fit.
package rllf_pkg;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic REG_WINDOW_TYPE = 1'b0;
  localparam logic REG_HALF_WIDTH  = 1'b1;

  localparam logic [30:0] HW_RESET = 31'd327680;
  localparam logic [15:0] W_ONE    = 16'd32768;
  localparam logic [10:0] PU_MAX   = 11'd2047;

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;
  localparam longint unsigned TAYLOR_DIV [12] =
    '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
      64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552};

  typedef enum logic [1:0] {
    FS_OK   = 2'd0,
    FS_FEW  = 2'd1,
    FS_SING = 2'd2,
    FS_SAT  = 2'd3
  } fit_status_t;

  typedef enum logic [4:0] {
    ST_NONE, ST_CLEAR, ST_LOAD, ST_QINIT, ST_READ, ST_DIFF, ST_CHK,
    ST_KINIT, ST_KSTEP, ST_MUL1, ST_TRUNC, ST_MUL2, ST_ACC,
    ST_PMUL, ST_PWAIT, ST_DIVGO, ST_DWAIT, ST_EMIT
  } step_t;

  typedef struct packed {
    step_t       step;
    logic [2:0]  sel;
    fit_status_t code;
  } dp_cmd_t;

  typedef struct packed {
    logic more;
    logic in_win;
    logic n_ge2;
    logic d_pos;
    logic k_last;
    logic mul_done;
    logic div_done;
    logic hann;
  } dp_sts_t;

  // Hann weight round(32768*cos(phi)^2), phi in Q30; elaboration only.
  function automatic logic [15:0] hann_entry(input longint unsigned phi);
    longint unsigned phi2;
    longint unsigned term;
    longint unsigned cm;
    longint unsigned w;
    longint          c;
    phi2 = (phi * phi) >> 30;
    term = ONE_Q30;
    c    = longint'(ONE_Q30);
    for (int n = 1; n <= 12; n++) begin
      term = ((term * phi2) >> 30) / TAYLOR_DIV[n-1];
      if (n[0]) c = c - longint'(term);
      else      c = c + longint'(term);
    end
    if (c < 0) c = 0;
    if (c > longint'(ONE_Q30)) c = longint'(ONE_Q30);
    cm = longint'(c);
    w  = (cm * cm + (64'd1 << 44)) >> 45;
    if (w > 64'd32768) w = 64'd32768;
    return w[15:0];
  endfunction

endpackage

// ===== rtl/core/rllf_ram.sv =====
// Generic single-port-write RAM with registered read.
module rllf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/rllf_mul.sv =====
// Bit-serial signed 64 x 64 multiplier, one partial product per cycle.
module rllf_mul (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [63:0]  a,
  input  logic signed [63:0]  b,
  output logic signed [127:0] p,
  output logic                done
);

  logic [127:0] ma;
  logic [63:0]  mb;
  logic [127:0] acc;
  logic         neg;
  logic [5:0]   cnt;
  logic         run;
  logic         fin;
  logic [63:0]  abs_a;
  logic [63:0]  abs_b;

  assign abs_a = a[63] ? 64'(-a) : 64'(a);
  assign abs_b = b[63] ? 64'(-b) : 64'(b);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ma  <= {64'd0, abs_a};
        mb  <= abs_b;
        acc <= '0;
        neg <= a[63] ^ b[63];
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        if (mb[0]) acc <= acc + ma;
        ma  <= ma << 1;
        mb  <= mb >> 1;
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end else if (fin) begin
        p    <= neg ? $signed(-acc) : $signed(acc);
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/rllf_div.sv =====
// Restoring divider: Q16.16 quotient of a signed 128-bit numerator, saturated.
module rllf_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [127:0] num,
  input  logic [127:0]        den,
  output logic [31:0]         q,
  output logic                sat,
  output logic                done
);

  logic [127:0] n;
  logic [127:0] rem;
  logic [127:0] r2;
  logic         ge;
  logic [31:0]  qlo;
  logic         hi;
  logic         neg;
  logic [6:0]   cnt;
  logic         run;
  logic         fin;
  logic [127:0] abs_num;

  assign abs_num = num[127] ? 128'(-num) : 128'(num);
  assign r2      = {rem[126:0], n[127]};
  assign ge      = r2 >= den;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        neg <= num[127];
        n   <= abs_num << 16;
        rem <= '0;
        qlo <= '0;
        hi  <= 1'b0;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        rem <= ge ? (r2 - den) : r2;
        n   <= n << 1;
        qlo <= {qlo[30:0], ge};
        hi  <= hi | qlo[31];
        cnt <= cnt + 7'd1;
        if (cnt == 7'd127) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
        if (neg) begin
          if (hi || qlo > 32'h8000_0000) begin
            q   <= 32'h8000_0000;
            sat <= 1'b1;
          end else begin
            q   <= -qlo;
            sat <= 1'b0;
          end
        end else begin
          if (hi || qlo[31]) begin
            q   <= 32'h7FFF_FFFF;
            sat <= 1'b1;
          end else begin
            q   <= qlo;
            sat <= 1'b0;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/core/rllf_ctrl.sv =====
// Controller: sequences loads, the sample walk and the closing arithmetic.
module rllf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        opcode,
  input  rllf_pkg::dp_sts_t sts,
  output rllf_pkg::dp_cmd_t cmd,
  output logic              busy
);

  import rllf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_READ, S_DIFF, S_CHK, S_KINIT, S_KSTEP, S_MUL1, S_TRUNC,
    S_MUL2, S_ACC, S_EVAL, S_PGO, S_PWAIT, S_DCHK, S_DGO, S_DWAIT, S_EMIT
  } state_t;

  state_t      state;
  logic [2:0]  sel;
  fit_status_t code;
  step_t       step;

  assign busy     = state != S_IDLE;
  assign cmd.step = step;
  assign cmd.sel  = sel;
  assign cmd.code = code;

  always_comb begin
    step = ST_NONE;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (opcode)
            OP_CLEAR: step = ST_CLEAR;
            OP_LOAD:  step = ST_LOAD;
            OP_QUERY: step = ST_QINIT;
            default:  step = ST_NONE;
          endcase
        end
      end
      S_READ:  step = sts.more ? ST_READ : ST_NONE;
      S_DIFF:  step = ST_DIFF;
      S_CHK:   step = ST_CHK;
      S_KINIT: step = ST_KINIT;
      S_KSTEP: step = ST_KSTEP;
      S_MUL1:  step = ST_MUL1;
      S_TRUNC: step = ST_TRUNC;
      S_MUL2:  step = ST_MUL2;
      S_ACC:   step = ST_ACC;
      S_PGO:   step = ST_PMUL;
      S_PWAIT: step = ST_PWAIT;
      S_DGO:   step = ST_DIVGO;
      S_DWAIT: step = ST_DWAIT;
      S_EMIT:  step = ST_EMIT;
      default: step = ST_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= '0;
      code  <= FS_OK;
    end else begin
      case (state)
        S_IDLE: begin
          if (start && opcode == OP_QUERY) state <= S_READ;
        end
        S_READ:  state <= sts.more ? S_DIFF : S_EVAL;
        S_DIFF:  state <= S_CHK;
        S_CHK: begin
          if (!sts.in_win)  state <= S_READ;
          else if (sts.hann) state <= S_KINIT;
          else              state <= S_MUL1;
        end
        S_KINIT: state <= S_KSTEP;
        S_KSTEP: begin
          if (sts.k_last) state <= S_MUL1;
        end
        S_MUL1:  state <= S_TRUNC;
        S_TRUNC: state <= S_MUL2;
        S_MUL2:  state <= S_ACC;
        S_ACC:   state <= S_READ;
        S_EVAL: begin
          sel <= '0;
          if (!sts.n_ge2) begin
            code  <= FS_FEW;
            state <= S_EMIT;
          end else begin
            state <= S_PGO;
          end
        end
        S_PGO: state <= S_PWAIT;
        S_PWAIT: begin
          if (sts.mul_done) begin
            if (sel == 3'd1) begin
              state <= S_DCHK;
            end else if (sel == 3'd5) begin
              sel   <= '0;
              state <= S_DGO;
            end else begin
              sel   <= sel + 3'd1;
              state <= S_PGO;
            end
          end
        end
        S_DCHK: begin
          if (!sts.d_pos) begin
            code  <= FS_SING;
            state <= S_EMIT;
          end else begin
            sel   <= 3'd2;
            state <= S_PGO;
          end
        end
        S_DGO: state <= S_DWAIT;
        S_DWAIT: begin
          if (sts.div_done) begin
            if (sel == 3'd0) begin
              sel   <= 3'd1;
              state <= S_DGO;
            end else begin
              code  <= FS_OK;
              state <= S_EMIT;
            end
          end
        end
        S_EMIT:  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/rllf_dp.sv =====
// Datapath: sample store, weights, running sums, products and quotients.
module rllf_dp #(
  parameter int MAX_SAMPLES    = 1024,
  parameter int COS_TABLE_SIZE = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic signed [31:0] sample_x,
  input  logic signed [31:0] sample_y,
  input  logic signed [31:0] query_x,
  input  rllf_pkg::dp_cmd_t  cmd,
  output rllf_pkg::dp_sts_t  sts,
  output logic               done,
  output logic signed [31:0] fitted_y,
  output logic signed [31:0] slope,
  output logic [1:0]         fit_status,
  output logic [10:0]        points_used
);

  import rllf_pkg::*;

  localparam int AW  = $clog2(MAX_SAMPLES);
  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam int SWW = 17 + CW;
  localparam int KW  = $clog2(COS_TABLE_SIZE);
  localparam int KCW = $clog2(KW);
  localparam int PW  = 31 + KW;
  localparam logic [KW:0]   N_K   = (KW+1)'(COS_TABLE_SIZE);
  localparam logic [KW-1:0] K_MAX = KW'(COS_TABLE_SIZE - 1);

  function automatic logic signed [31:0] trunc15(input logic signed [48:0] p);
    logic signed [48:0] t;
    t = p + (p[48] ? 49'sd32767 : 49'sd0);
    return t[46:15];
  endfunction

  function automatic logic signed [63:0] trunc16(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + (p[63] ? 64'sd65535 : 64'sd0);
    return {{16{t[63]}}, t[63:16]};
  endfunction

  // configuration
  logic        window_type;
  logic [30:0] half_width;

  // store
  logic [CW-1:0] count;
  logic [CW-1:0] j;
  logic [CW-1:0] n;
  logic          ram_we;
  logic [63:0]   rdata;

  // per-sample pipeline registers
  logic signed [31:0] q;
  logic signed [32:0] u;
  logic signed [31:0] yv;
  logic [32:0]        au;
  logic [30:0]        dmag;
  logic [30:0]        rem;
  logic [KW-1:0]      low;
  logic [KW-1:0]      kq;
  logic [KCW-1:0]     kcnt;
  logic [PW-1:0]      kprod;
  logic [31:0]        trial;
  logic               kge;
  logic [KW-1:0]      kidx;
  logic [15:0]        hann_rom [COS_TABLE_SIZE];
  logic [15:0]        w_cur;
  logic [15:0]        wreg;
  logic signed [16:0] wsg;
  logic signed [31:0] u32;
  logic signed [48:0] pw;
  logic signed [48:0] py;
  logic signed [31:0] wu;
  logic signed [31:0] wy;
  logic signed [63:0] puu;
  logic signed [63:0] puy;

  // sums
  logic [SWW-1:0]     sw;
  logic signed [63:0] swu;
  logic signed [63:0] swy;
  logic signed [63:0] suu;
  logic signed [63:0] suy;
  logic signed [63:0] s2;

  // closing arithmetic
  logic signed [63:0]  ma;
  logic signed [63:0]  mb;
  logic signed [127:0] mp;
  logic                mdone;
  logic signed [127:0] t;
  logic signed [127:0] d;
  logic signed [127:0] ns;
  logic signed [127:0] na;
  logic [31:0]         dq;
  logic                dsat;
  logic                ddone;
  logic [31:0]         sl;
  logic [31:0]         fy;
  logic                sat_sl;
  logic                sat_fy;
  logic [CW+10:0]      n_ext;

  for (genvar g = 0; g < COS_TABLE_SIZE; g++) begin : g_hann
    localparam longint unsigned PHI = (PI_Q30 * 64'(g)) / 64'(2 * COS_TABLE_SIZE);
    assign hann_rom[g] = hann_entry(PHI);
  end

  assign ram_we = (cmd.step == ST_LOAD) && (count < CW'(MAX_SAMPLES));

  rllf_ram #(
    .WIDTH (64),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata ({sample_x, sample_y}),
    .re    (cmd.step == ST_READ),
    .raddr (j[AW-1:0]),
    .rdata (rdata)
  );

  assign au    = u[32] ? 33'(-u) : 33'(u);
  assign kprod = PW'(dmag) * PW'(COS_TABLE_SIZE);
  assign trial = {rem, low[KW-1]};
  assign kge   = trial >= {1'b0, half_width};
  assign kidx  = ({1'b0, kq} >= N_K) ? K_MAX : kq;
  assign w_cur = window_type ? hann_rom[kidx] : W_ONE;
  assign wsg   = $signed({1'b0, w_cur});
  assign u32   = u[31:0];
  assign s2    = 64'({sw, 1'b0});

  always_comb begin
    case (cmd.sel)
      3'd0:    begin ma = s2;  mb = suu; end
      3'd1:    begin ma = swu; mb = swu; end
      3'd2:    begin ma = s2;  mb = suy; end
      3'd3:    begin ma = swu; mb = swy; end
      3'd4:    begin ma = suu; mb = swy; end
      3'd5:    begin ma = swu; mb = suy; end
      default: begin ma = swu; mb = swu; end
    endcase
  end

  rllf_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.step == ST_PMUL),
    .a     (ma),
    .b     (mb),
    .p     (mp),
    .done  (mdone)
  );

  rllf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.step == ST_DIVGO),
    .num   (cmd.sel[0] ? na : ns),
    .den   (d),
    .q     (dq),
    .sat   (dsat),
    .done  (ddone)
  );

  assign sts.more     = j < count;
  assign sts.in_win   = au < {2'b00, half_width};
  assign sts.n_ge2    = n >= CW'(2);
  assign sts.d_pos    = !d[127] && (d != '0);
  assign sts.k_last   = kcnt == KCW'(KW - 1);
  assign sts.mul_done = mdone;
  assign sts.div_done = ddone;
  assign sts.hann     = window_type;

  assign n_ext = {11'd0, n};

  always_ff @(posedge clk) begin
    if (rst) begin
      window_type <= 1'b0;
      half_width  <= HW_RESET;
      count       <= '0;
      done        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW_TYPE: window_type <= cfg_data[0];
          REG_HALF_WIDTH:  half_width  <= cfg_data;
          default:         window_type <= window_type;
        endcase
      end
      if (cmd.step == ST_CLEAR) count <= '0;
      else if (ram_we)          count <= count + CW'(1);
      done <= cmd.step == ST_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.step)
      ST_QINIT: begin
        q   <= query_x;
        j   <= '0;
        n   <= '0;
        sw  <= '0;
        swu <= '0;
        swy <= '0;
        suu <= '0;
        suy <= '0;
      end
      ST_READ: j <= j + CW'(1);
      ST_DIFF: begin
        u  <= {rdata[63], rdata[63:32]} - {q[31], q};
        yv <= rdata[31:0];
      end
      ST_CHK: dmag <= au[30:0];
      ST_KINIT: begin
        rem  <= kprod[PW-1:KW];
        low  <= kprod[KW-1:0];
        kq   <= '0;
        kcnt <= '0;
      end
      ST_KSTEP: begin
        // one quotient bit of distance*N / half_width
        rem  <= kge ? 31'(trial - {1'b0, half_width}) : trial[30:0];
        low  <= low << 1;
        kq   <= {kq[KW-2:0], kge};
        kcnt <= kcnt + KCW'(1);
      end
      ST_MUL1: begin
        wreg <= w_cur;
        pw   <= wsg * u32;
        py   <= wsg * yv;
      end
      ST_TRUNC: begin
        wu <= trunc15(pw);
        wy <= trunc15(py);
      end
      ST_MUL2: begin
        puu <= wu * u32;
        puy <= wu * yv;
      end
      ST_ACC: begin
        sw  <= sw + SWW'(wreg);
        swu <= swu + 64'(wu);
        swy <= swy + 64'(wy);
        suu <= suu + trunc16(puu);
        suy <= suy + trunc16(puy);
        n   <= n + CW'(1);
      end
      ST_PWAIT: begin
        if (mdone) begin
          if (!cmd.sel[0]) begin
            t <= mp;
          end else begin
            case (cmd.sel[2:1])
              2'd0:    d  <= t - mp;
              2'd1:    ns <= t - mp;
              default: na <= t - mp;
            endcase
          end
        end
      end
      ST_DWAIT: begin
        if (ddone) begin
          if (cmd.sel[0]) begin
            fy     <= dq;
            sat_fy <= dsat;
          end else begin
            sl     <= dq;
            sat_sl <= dsat;
          end
        end
      end
      ST_EMIT: begin
        fitted_y    <= (cmd.code == FS_OK) ? fy : 32'd0;
        slope       <= (cmd.code == FS_OK) ? sl : 32'd0;
        fit_status  <= (cmd.code == FS_OK && (sat_sl || sat_fy)) ? FS_SAT : cmd.code;
        points_used <= (n_ext > (CW+11)'(PU_MAX)) ? PU_MAX : n_ext[10:0];
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/running_local_linear_fit.sv =====
// Running local linear fit: clear and load complete while busy stays low; a query
// holds busy while it walks the stored samples one RAM read at a time, with extra
// steps for samples inside the window (and a bit-serial index division with Hann
// weights), then runs six 64 x 64 products on a bit-serial multiplier and two
// quotients on a restoring divider (ending early on too few points or a singular
// fit). The result appears for exactly one cycle with done high; the receiver
// cannot stall it, so it must take it in that cycle.
module running_local_linear_fit #(
  parameter int MAX_SAMPLES    = 1024,
  parameter int COS_TABLE_SIZE = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode,
  input  logic signed [31:0] sample_x,
  input  logic signed [31:0] sample_y,
  input  logic signed [31:0] query_x,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [30:0]        cfg_data,
  output logic               done,
  output logic signed [31:0] fitted_y,
  output logic signed [31:0] slope,
  output logic [1:0]         fit_status,
  output logic [10:0]        points_used
);

  import rllf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  rllf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  rllf_dp #(
    .MAX_SAMPLES    (MAX_SAMPLES),
    .COS_TABLE_SIZE (COS_TABLE_SIZE)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample_x    (sample_x),
    .sample_y    (sample_y),
    .query_x     (query_x),
    .cmd         (cmd),
    .sts         (sts),
    .done        (done),
    .fitted_y    (fitted_y),
    .slope       (slope),
    .fit_status  (fit_status),
    .points_used (points_used)
  );

endmodule

// ===== tb/sv/tb_running_local_linear_fit.sv =====
// Self-checking testbench for the running local linear fit: directed and random items.
module tb_running_local_linear_fit;
  import rllf_pkg::*;

  localparam int NSAMP     = 1024;
  localparam int NCOS      = 256;
  localparam int IDLE_LIMIT = 400000;

  typedef struct packed {
    logic [31:0] fy;
    logic [31:0] sl;
    logic [1:0]  st;
    logic [10:0] pu;
  } fit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] opcode = OP_CLEAR;
  logic signed [31:0] sample_x = '0, sample_y = '0, query_x = '0;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_WINDOW_TYPE;
  logic [30:0] cfg_data = '0;
  logic done;
  logic signed [31:0] fitted_y, slope;
  logic [1:0] fit_status;
  logic [10:0] points_used;

  running_local_linear_fit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .sample_x(sample_x), .sample_y(sample_y), .query_x(query_x),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .fitted_y(fitted_y), .slope(slope),
    .fit_status(fit_status), .points_used(points_used)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state
  logic [31:0] xs [NSAMP];
  logic [31:0] ys [NSAMP];
  int unsigned n_stored;
  logic        hann_on;
  logic [30:0] hw;
  longint unsigned hann_w [NCOS];
  fit_t fits_due [$];
  int errors;
  int idle_cycles;
  bit no_gaps;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void make_hann_table();
    longint unsigned phi, phi2, term, cm, w;
    longint c;
    for (int k = 0; k < NCOS; k++) begin
      phi  = PI_Q30 * longint'(k) / (2 * NCOS);
      phi2 = (phi * phi) >> 30;
      term = ONE_Q30;
      c    = longint'(ONE_Q30);
      for (int n = 1; n <= 12; n++) begin
        term = ((term * phi2) >> 30) / longint'((2 * n - 1) * (2 * n));
        if (n % 2 == 1) c -= longint'(term);
        else c += longint'(term);
      end
      if (c < 0) c = 0;
      if (c > longint'(ONE_Q30)) c = longint'(ONE_Q30);
      cm = c;
      w  = (cm * cm + (64'd1 << 44)) >> 45;
      hann_w[k] = (w > 32768) ? 32768 : w;
    end
  endfunction

  // Q16.16 quotient, truncated toward zero, saturating to int32
  function automatic logic [31:0] q16_div(input logic signed [191:0] num,
                                         input logic signed [191:0] den, inout bit sat);
    logic signed [191:0] qq;
    qq = (num * 65536) / den;
    if (qq > 192'sd2147483647) begin
      sat = 1;
      return 32'h7FFFFFFF;
    end
    if (qq < -192'sd2147483648) begin
      sat = 1;
      return 32'h80000000;
    end
    return qq[31:0];
  endfunction

  function automatic fit_t local_fit(input logic signed [31:0] qx);
    longint q, u, y, w, wu, wy, sw, swu, swy, suu, suy;
    longint unsigned dmag, k;
    int unsigned n;
    logic signed [191:0] bsw, bswu, bswy, bsuu, bsuy, d;
    bit sat;
    fit_t r;
    q = qx;
    sw = 0; swu = 0; swy = 0; suu = 0; suy = 0; n = 0; sat = 0;
    r = '0;
    for (int j = 0; j < n_stored; j++) begin
      u = longint'($signed(xs[j])) - q;
      y = $signed(ys[j]);
      dmag = (u < 0) ? -u : u;
      if (dmag >= hw) continue;
      if (!hann_on) w = 32768;
      else begin
        k = dmag * NCOS / hw;
        if (k >= NCOS) k = NCOS - 1;
        w = hann_w[k];
      end
      wu = (w * u) / 32768;
      wy = (w * y) / 32768;
      sw += w;
      swu += wu;
      swy += wy;
      suu += (wu * u) / 65536;
      suy += (wu * y) / 65536;
      n++;
    end
    r.pu = (n > 2047) ? PU_MAX : n[10:0];
    if (n < 2) begin
      r.st = FS_FEW;
      return r;
    end
    bsw = sw; bswu = swu; bswy = swy; bsuu = suu; bsuy = suy;
    d = 2 * bsw * bsuu - bswu * bswu;
    if (d <= 0) begin
      r.st = FS_SING;
      return r;
    end
    r.sl = q16_div(2 * bsw * bsuy - bswu * bswy, d, sat);
    r.fy = q16_div(bsuu * bswy - bswu * bsuy, d, sat);
    r.st = sat ? FS_SAT : FS_OK;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [31:0] sx,
                           input logic [31:0] sy, input logic [31:0] qx);
    int gap;
    start    <= 1'b1;
    opcode   <= op;
    sample_x <= sx;
    sample_y <= sy;
    query_x  <= qx;
    do @(posedge clk); while (busy);
    case (op)
      OP_CLEAR: n_stored = 0;
      OP_LOAD: if (n_stored < NSAMP) begin
        xs[n_stored] = sx;
        ys[n_stored] = sy;
        n_stored++;
      end
      OP_QUERY: fits_due.push_back(local_fit(qx));
      default: ;
    endcase
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // waits for every result, lets the block settle, then writes both registers
  task automatic set_window(input logic wt, input logic [30:0] half);
    start <= 1'b0;
    while (fits_due.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_WINDOW_TYPE;
    cfg_data <= {30'd0, wt};
    @(posedge clk);
    cfg_index <= REG_HALF_WIDTH;
    cfg_data <= half;
    @(posedge clk);
    cfg_we <= 1'b0;
    hann_on = wt;
    hw = half;
    @(posedge clk);
  endtask

  task automatic test_directed();
    set_window(1'b0, HW_RESET);
    send_item(OP_CLEAR, 0, 0, 0);
    send_item(OP_QUERY, 0, 0, 0);
    send_item(OP_LOAD, 0, 32'h10000, 0);
    send_item(OP_QUERY, 0, 0, 0);
    send_item(OP_LOAD, 32'h10000, 32'h30000, 0);
    send_item(OP_LOAD, 32'h20000, 32'h48000, 0);
    send_item(OP_QUERY, 0, 0, 32'h8000);
    send_item(2'd3, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    // steep line: slope overflows
    send_item(OP_CLEAR, 0, 0, 0);
    send_item(OP_LOAD, 0, 32'h80000000, 0);
    send_item(OP_LOAD, 1, 32'h7FFFFFFF, 0);
    send_item(OP_QUERY, 0, 0, 0);
    // coincident abscissae: zero denominator
    send_item(OP_CLEAR, 0, 0, 0);
    send_item(OP_LOAD, 100, 5, 0);
    send_item(OP_LOAD, 100, 9, 0);
    send_item(OP_QUERY, 0, 0, 100);
    send_item(OP_LOAD, 32'h7FFFFFFF, 32'h80000000, 0);
    send_item(OP_LOAD, 32'h80000000, 32'h7FFFFFFF, 0);
    send_item(OP_QUERY, 0, 0, 32'h7FFFFFFF);
    send_item(OP_QUERY, 0, 0, 32'h80000000);
    set_window(1'b1, 31'h7FFFFFFF);
    send_item(OP_QUERY, 0, 0, 0);
    send_item(OP_QUERY, 0, 0, 32'h7FFFFFFF);
    set_window(1'b1, 31'd0);
    send_item(OP_QUERY, 0, 0, 100);
  endtask

  task automatic random_phase(input logic wt, input logic [30:0] half, input int items);
    longint centre, span, xv;
    logic [31:0] yv;
    int sent, npts;
    set_window(wt, half);
    no_gaps = ($urandom_range(0, 3) == 0);
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 99) < 15) begin
        send_item($urandom_range(0, 3), $urandom, $urandom, $urandom);
        sent++;
        continue;
      end
      centre = $signed($urandom);
      span = (half == 0) ? 64'd65536 : longint'(half);
      if ($urandom_range(0, 4) != 0) begin
        send_item(OP_CLEAR, 0, 0, 0);
        sent++;
      end
      npts = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 10);
      for (int i = 0; i < npts; i++) begin
        xv = centre + longint'($urandom_range(0, 32'hFFFFFFFF)) % (3 * span) - span;
        yv = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'hFFFFF) - 32'h80000;
        send_item(OP_LOAD, xv[31:0], yv, 0);
        sent++;
      end
      repeat ($urandom_range(1, 3)) begin
        xv = centre + longint'($urandom_range(0, 32'hFFFFFFFF)) % span - span / 2;
        send_item(OP_QUERY, 0, 0, xv[31:0]);
        sent++;
      end
    end
    no_gaps = 0;
  endtask

  task automatic test_random();
    random_phase(1'b0, HW_RESET, 60);
    random_phase(1'b1, HW_RESET, 70);
    random_phase(1'b0, 31'd1, 35);
    random_phase(1'b1, 31'h7FFFFFFF, 60);
    random_phase(1'b1, 31'd196608, 70);
    random_phase(1'b0, 31'h7FFFFFFF, 55);
    random_phase(1'b0, 31'd0, 25);
    random_phase(1'b1, $urandom_range(1, 32'h7FFFFFFF), 60);
    random_phase(1'b1, $urandom_range(16, 32'hFFFFF), 60);
  endtask

  // results are taken in the one cycle that done is high
  always @(posedge clk) begin
    fit_t want;
    if (!rst && done) begin
      if (fits_due.size() == 0) begin
        $display("unexpected result at %0t", $realtime);
        errors++;
      end else begin
        want = fits_due.pop_front();
        if (fitted_y !== want.fy) report("fitted_y", fitted_y, want.fy);
        if (slope !== want.sl) report("slope", slope, want.sl);
        if (fit_status !== want.st) report("fit_status", fit_status, want.st);
        if (points_used !== want.pu) report("points_used", points_used, want.pu);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    errors = 0;
    no_gaps = 0;
    n_stored = 0;
    hann_on = 1'b0;
    hw = HW_RESET;
    make_hann_table();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    start <= 1'b0;
    while (fits_due.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
